@@ rtl/core/pcm_voice_mixer_macros.svh @@
// Assertion macros for the PCM voice mixer
`ifndef PCM_VOICE_MIXER_MACROS_SVH
`define PCM_VOICE_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define PVM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pcm_voice_mixer check failed");
`define PVM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pcm_voice_mixer sequence check failed");
`else
`define PVM_ASSERT(lbl, prop)
`define PVM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/core/pvm_pkg.sv @@
// Types and constants of the PCM voice mixer
package pvm_pkg;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_PLAY = 2'd1,
    ACT_STOP = 2'd2,
    ACT_LOAD = 2'd3
  } action_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV   = 9'b000000010,
    ST_VSEL  = 9'b000000100,
    ST_VLOAD = 9'b000001000,
    ST_VMUL  = 9'b000010000,
    ST_VADV  = 9'b000100000,
    ST_VWRAP = 9'b001000000,
    ST_MGAIN = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned LEVEL_W      = 9;
  localparam int unsigned GAIN_W       = 10;
  localparam int unsigned MUL_STEPS    = 10;
  localparam int unsigned DIV_STEPS    = 32;
  localparam logic [LEVEL_W-1:0] LEVEL_UNITY = 9'd256;
  localparam logic [GAIN_W-1:0]  MASTER_RESET = 10'd256;
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

endpackage

@@ rtl/core/pcm_voice_mixer.sv @@
// PCM voice mixer top level: sample store, voice table and bit-serial arithmetic
//
//  channel   direction  handshake                 payload
//  in_       in         start / busy              action, address, data, voice setup
//  out_      out        out_valid strobe          mixed_left, mixed_right
//  cfg_      in         cfg_valid / cfg_ready     cfg_master_gain
//
// Load and stop are done from idle without raising busy; play runs the bit-serial step
// divider (32 steps). On a tick each active voice goes through a 10-step shift-add gain
// multiplier, then the master gain uses the same multiplier.
// Reset clears all voices and sets master gain to unity; the sample store keeps its data.
// The result strobe lasts one cycle and cannot be held off.
`include "pcm_voice_mixer_macros.svh"

module pcm_voice_mixer #(
  parameter int unsigned VOICES       = 8,
  parameter int unsigned OUTPUT_HZ    = 32000,
  parameter int unsigned SAMPLE_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_sample_addr,
  input  logic signed [15:0] in_sample_data,
  input  logic [16:0]        in_sample_count,
  input  logic [15:0]        in_sample_rate,
  input  logic [16:0]        in_loop_begin,
  input  logic [16:0]        in_loop_finish,
  input  logic               in_loop_enable,
  input  logic signed [10:0] in_voice_gain,
  input  logic               in_music_voice,
  output logic               out_valid,
  output logic signed [15:0] out_mixed_left,
  output logic signed [15:0] out_mixed_right,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_master_gain
);

  localparam int unsigned AW   = $clog2(SAMPLE_WORDS);
  localparam int unsigned VW   = $clog2(VOICES);
  localparam int unsigned STW  = $clog2(((64'd65535 << 16) / OUTPUT_HZ) + 2);
  localparam int unsigned DW   = $clog2(OUTPUT_HZ + 1);
  localparam int unsigned ACCW = 17 + $clog2(VOICES);
  localparam int unsigned PW   = ACCW + 11;
  localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);
  localparam logic [DW:0]   DIVISOR    = (DW + 1)'(OUTPUT_HZ);

  logic [15:0] mem [SAMPLE_WORDS];
  logic [15:0] rdata_r;

  logic [VOICES-1:0] act_r, act_nxt;
  logic [15:0]       base_r  [VOICES];
  logic [16:0]       len_r   [VOICES];
  logic [16:0]       ls_r    [VOICES];
  logic [16:0]       le_r    [VOICES];
  logic [STW-1:0]    step_r  [VOICES];
  logic [31:0]       phase_r [VOICES];
  logic              loop_r  [VOICES];
  logic [8:0]        level_r [VOICES];

  pvm_pkg::state_t state_r, state_nxt;
  logic [VW-1:0]   v_r, v_nxt;
  logic [9:0]      mg_r, mg_nxt;

  logic [VW-1:0]   p_slot_r;
  logic [15:0]     p_base_r;
  logic [16:0]     p_len_r, p_ls_r, p_le_r;
  logic            p_loop_r;
  logic [8:0]      p_level_r;
  logic [4:0]      dcnt_r, dcnt_nxt;
  logic [31:0]     dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [DW:0]     rem_r, rem_nxt, rem_t;

  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0]   prod_r, prod_nxt, mcand_r, mcand_nxt, q;
  logic [9:0]             mult_r, mult_nxt;
  logic [3:0]             mcnt_r, mcnt_nxt;

  logic               ov_r, ov_nxt;
  logic signed [15:0] mix_r, mix_nxt;

  logic accept, play_acc;
  logic [VW-1:0] slot;
  logic [16:0]   le_sel;
  logic [8:0]    lvl_sel;
  logic [15:0]   idx;
  logic [AW-1:0] raddr;
  logic          advance;
  logic          ph_we, p_we;
  logic [31:0]   ph_wval;
  logic [16:0]   ldiff;

  assign accept    = start && !busy;
  assign busy      = state_r != pvm_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_mixed_left  = mix_r;
  assign out_mixed_right = mix_r;
  assign play_acc  = accept && in_action == pvm_pkg::ACT_PLAY && in_sample_count != 17'd0;

  assign idx   = phase_r[v_r][31:16];
  assign raddr = base_r[v_r][AW-1:0] + idx[AW-1:0];
  assign ldiff = le_r[v_r] - ls_r[v_r];
  assign rem_t = {rem_r[DW-1:0], dvd_r[31]};

  always_comb begin
    slot = VW'(1);
    for (int i = VOICES - 1; i >= 1; i--) begin
      if (!act_r[i]) begin
        slot = VW'(i);
      end
    end
    if (in_music_voice) begin
      slot = '0;
    end
    if (in_loop_finish > in_loop_begin && in_loop_finish <= in_sample_count) begin
      le_sel = in_loop_finish;
    end else begin
      le_sel = in_sample_count;
    end
    priority if (in_voice_gain[10]) begin
      lvl_sel = '0;
    end else if (in_voice_gain > 11'sd256) begin
      lvl_sel = pvm_pkg::LEVEL_UNITY;
    end else begin
      lvl_sel = in_voice_gain[8:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    act_nxt   = act_r;
    mg_nxt    = mg_r;
    dcnt_nxt  = dcnt_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    mcnt_nxt  = mcnt_r;
    ov_nxt    = 1'b0;
    mix_nxt   = mix_r;
    advance   = 1'b0;
    ph_we     = 1'b0;
    ph_wval   = phase_r[v_r];
    p_we      = 1'b0;
    q         = prod_r >>> 8;

    if (cfg_valid) begin
      mg_nxt = cfg_master_gain;
    end

    unique case (state_r)
      pvm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (pvm_pkg::action_t'(in_action))
            pvm_pkg::ACT_TICK: begin
              acc_nxt   = '0;
              v_nxt     = '0;
              state_nxt = pvm_pkg::ST_VSEL;
            end
            pvm_pkg::ACT_PLAY: begin
              if (play_acc) begin
                dvd_nxt   = {in_sample_rate, 16'h0000};
                rem_nxt   = '0;
                quo_nxt   = '0;
                dcnt_nxt  = '0;
                state_nxt = pvm_pkg::ST_DIV;
              end
            end
            pvm_pkg::ACT_STOP: begin
              act_nxt = '0;
            end
            pvm_pkg::ACT_LOAD: begin
            end
            default: begin
            end
          endcase
        end
      end
      pvm_pkg::ST_DIV: begin
        if (rem_t >= DIVISOR) begin
          rem_nxt = rem_t - DIVISOR;
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_t;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'(pvm_pkg::DIV_STEPS - 1)) begin
          p_we      = 1'b1;
          act_nxt[p_slot_r] = 1'b1;
          state_nxt = pvm_pkg::ST_IDLE;
        end
      end
      pvm_pkg::ST_VSEL: begin
        if (!act_r[v_r]) begin
          advance = 1'b1;
        end else if ({1'b0, idx} >= len_r[v_r]) begin
          act_nxt[v_r] = 1'b0;
          advance      = 1'b1;
        end else begin
          state_nxt = pvm_pkg::ST_VLOAD;
        end
      end
      pvm_pkg::ST_VLOAD: begin
        mcand_nxt = {{(PW - 16){rdata_r[15]}}, rdata_r};
        mult_nxt  = {1'b0, level_r[v_r]};
        prod_nxt  = '0;
        mcnt_nxt  = '0;
        state_nxt = pvm_pkg::ST_VMUL;
      end
      pvm_pkg::ST_VMUL, pvm_pkg::ST_MGAIN: begin
        if (mult_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt = mcand_r <<< 1;
        mult_nxt  = mult_r >> 1;
        mcnt_nxt  = mcnt_r + 4'd1;
        if (mcnt_r == 4'(pvm_pkg::MUL_STEPS - 1)) begin
          if (state_r == pvm_pkg::ST_VMUL) begin
            q         = prod_nxt >>> 8;
            acc_nxt   = acc_r + q[ACCW-1:0];
            state_nxt = pvm_pkg::ST_VADV;
          end else begin
            state_nxt = pvm_pkg::ST_DONE;
          end
        end
      end
      pvm_pkg::ST_VADV: begin
        ph_we     = 1'b1;
        ph_wval   = phase_r[v_r] + 32'(step_r[v_r]);
        state_nxt = pvm_pkg::ST_VWRAP;
      end
      pvm_pkg::ST_VWRAP: begin
        if (loop_r[v_r]) begin
          if ({1'b0, idx} >= le_r[v_r]) begin
            ph_we   = 1'b1;
            ph_wval = phase_r[v_r] - {ldiff[15:0], 16'h0000};
          end
        end else if ({1'b0, idx} >= len_r[v_r]) begin
          act_nxt[v_r] = 1'b0;
        end
        advance = 1'b1;
      end
      pvm_pkg::ST_DONE: begin
        priority if (!q[PW-1] && (|q[PW-2:15])) begin
          mix_nxt = pvm_pkg::SAT_MAX;
        end else if (q[PW-1] && !(&q[PW-2:15])) begin
          mix_nxt = pvm_pkg::SAT_MIN;
        end else begin
          mix_nxt = q[15:0];
        end
        ov_nxt    = 1'b1;
        state_nxt = pvm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pvm_pkg::ST_IDLE;
      end
    endcase

    if (advance) begin
      if (v_r == LAST_VOICE) begin
        mcand_nxt = {{(PW - ACCW){acc_nxt[ACCW-1]}}, acc_nxt};
        mult_nxt  = mg_r;
        prod_nxt  = '0;
        mcnt_nxt  = '0;
        state_nxt = pvm_pkg::ST_MGAIN;
      end else begin
        v_nxt     = v_r + VW'(1);
        state_nxt = pvm_pkg::ST_VSEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvm_pkg::ST_IDLE;
      act_r   <= '0;
      mg_r    <= pvm_pkg::MASTER_RESET;
      ov_r    <= 1'b0;
      v_r     <= '0;
      dcnt_r  <= '0;
      mcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      mg_r    <= mg_nxt;
      ov_r    <= ov_nxt;
      v_r     <= v_nxt;
      dcnt_r  <= dcnt_nxt;
      mcnt_r  <= mcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    mix_r   <= mix_nxt;
    if (play_acc && state_r == pvm_pkg::ST_IDLE) begin
      p_slot_r  <= slot;
      p_base_r  <= in_sample_addr;
      p_len_r   <= in_sample_count;
      p_ls_r    <= in_loop_begin;
      p_le_r    <= le_sel;
      p_loop_r  <= in_loop_enable;
      p_level_r <= lvl_sel;
    end
    if (p_we) begin
      base_r[p_slot_r]  <= p_base_r;
      len_r[p_slot_r]   <= p_len_r;
      ls_r[p_slot_r]    <= p_ls_r;
      le_r[p_slot_r]    <= p_le_r;
      step_r[p_slot_r]  <= (quo_nxt == 32'd0) ? STW'(1) : quo_nxt[STW-1:0];
      phase_r[p_slot_r] <= '0;
      loop_r[p_slot_r]  <= p_loop_r;
      level_r[p_slot_r] <= p_level_r;
    end
    if (ph_we) begin
      phase_r[v_r] <= ph_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_action == pvm_pkg::ACT_LOAD) begin
      mem[in_sample_addr[AW-1:0]] <= in_sample_data;
    end
    rdata_r <= mem[raddr];
  end

  `PVM_ASSERT(a_strobe_idle, out_valid |-> !busy)
  `PVM_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `PVM_ASSERT_NEXT(a_tick_busy, accept && in_action == pvm_pkg::ACT_TICK, busy)
  `PVM_ASSERT(a_mul_bound, (state_r == pvm_pkg::ST_VMUL) |-> (mcnt_r < 4'd10))

endmodule

@@ verif/pcm_voice_mixer_test.sv @@
// Self-checking testbench for the PCM voice mixer: directed and random item streams
module pcm_voice_mixer_test;

  localparam int NV = 8;
  localparam int RATE_HZ = 32000;
  localparam int TICK_CYCLES = NV * 14 + 12;
  localparam int STALL_LIMIT = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = pvm_pkg::ACT_TICK;
  logic [15:0] in_sample_addr = '0;
  logic signed [15:0] in_sample_data = '0;
  logic [16:0] in_sample_count = '0;
  logic [15:0] in_sample_rate = '0;
  logic [16:0] in_loop_begin = '0;
  logic [16:0] in_loop_finish = '0;
  logic in_loop_enable = 1'b0;
  logic signed [10:0] in_voice_gain = '0;
  logic in_music_voice = 1'b0;
  logic out_valid;
  logic signed [15:0] out_mixed_left;
  logic signed [15:0] out_mixed_right;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [9:0] cfg_master_gain = '0;

  pcm_voice_mixer uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_sample_addr(in_sample_addr),
    .in_sample_data(in_sample_data), .in_sample_count(in_sample_count),
    .in_sample_rate(in_sample_rate), .in_loop_begin(in_loop_begin),
    .in_loop_finish(in_loop_finish), .in_loop_enable(in_loop_enable),
    .in_voice_gain(in_voice_gain), .in_music_voice(in_music_voice),
    .out_valid(out_valid), .out_mixed_left(out_mixed_left),
    .out_mixed_right(out_mixed_right), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_master_gain(cfg_master_gain)
  );

  always #5 clk = ~clk;

  logic [15:0] store_word [0:65535];
  bit          store_written [0:65535];
  bit          v_on [NV];
  logic [15:0] v_base [NV];
  logic [16:0] v_len [NV];
  logic [16:0] v_lstart [NV];
  logic [16:0] v_lend [NV];
  logic [31:0] v_step [NV];
  logic [31:0] v_phase [NV];
  bit          v_loop [NV];
  logic [8:0]  v_level [NV];
  logic [9:0]  mgain = pvm_pkg::MASTER_RESET;

  logic signed [15:0] frames_due [$];
  int xfer_count = 0;
  int cfg_count = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  function automatic logic signed [15:0] mix_tick();
    longint acc;
    logic [31:0] idx;
    acc = 0;
    for (int i = 0; i < NV; i++) begin
      if (v_on[i]) begin
        idx = v_phase[i] >> 16;
        if (idx >= v_len[i]) begin
          v_on[i] = 0;
        end else begin
          acc += (longint'($signed(store_word[16'(v_base[i] + idx)])) *
                  longint'(v_level[i])) >>> 8;
          v_phase[i] = v_phase[i] + v_step[i];
          idx = v_phase[i] >> 16;
          if (v_loop[i]) begin
            if (idx >= v_lend[i])
              v_phase[i] = v_phase[i] - ((32'(v_lend[i]) - 32'(v_lstart[i])) << 16);
          end else if (idx >= v_len[i]) begin
            v_on[i] = 0;
          end
        end
      end
    end
    acc = (acc * longint'(mgain)) >>> 8;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return 16'(acc);
  endfunction

  function automatic void start_voice();
    int slot;
    longint stp;
    int g;
    if (in_sample_count == 0) return;
    slot = -1;
    if (in_music_voice) begin
      slot = 0;
    end else begin
      for (int i = 1; i < NV; i++)
        if (slot < 0 && !v_on[i]) slot = i;
      if (slot < 0) slot = 1;
    end
    g = int'(in_voice_gain);
    v_base[slot] = in_sample_addr;
    v_len[slot] = in_sample_count;
    v_lstart[slot] = in_loop_begin;
    v_lend[slot] = (in_loop_finish > in_loop_begin && in_loop_finish <= in_sample_count) ?
                   in_loop_finish : in_sample_count;
    stp = (longint'(in_sample_rate) << 16) / RATE_HZ;
    v_step[slot] = (stp == 0) ? 32'd1 : 32'(stp);
    v_phase[slot] = 0;
    v_loop[slot] = in_loop_enable;
    v_level[slot] = (g < 0) ? 9'd0 : (g > 256 ? pvm_pkg::LEVEL_UNITY : 9'(g));
    v_on[slot] = 1;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        xfer_count++;
        case (pvm_pkg::action_t'(in_action))
          pvm_pkg::ACT_TICK: frames_due.push_back(mix_tick());
          pvm_pkg::ACT_PLAY: start_voice();
          pvm_pkg::ACT_STOP: for (int i = 0; i < NV; i++) v_on[i] = 0;
          pvm_pkg::ACT_LOAD: begin
            store_word[in_sample_addr] = in_sample_data;
            store_written[in_sample_addr] = 1;
          end
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        cfg_count++;
        mgain = cfg_master_gain;
      end
      if (out_valid) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected frame %0d/%0d", out_mixed_left, out_mixed_right);
        end else begin
          if (out_mixed_left !== frames_due[0] || out_mixed_right !== frames_due[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame mismatch: expected %0d, got left %0d right %0d",
                       frames_due[0], out_mixed_left, out_mixed_right);
          end
          void'(frames_due.pop_front());
        end
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send(pvm_pkg::action_t act, logic [15:0] addr = 0, logic [15:0] data = 0,
                      logic [16:0] cnt = 0, logic [15:0] rate = 0,
                      logic [16:0] lb = 0, logic [16:0] lf = 0, bit le = 0,
                      logic [10:0] g = 0, bit mus = 0);
    int n0;
    n0 = xfer_count;
    in_action <= act;
    in_sample_addr <= addr;
    in_sample_data <= data;
    in_sample_count <= cnt;
    in_sample_rate <= rate;
    in_loop_begin <= lb;
    in_loop_finish <= lf;
    in_loop_enable <= le;
    in_voice_gain <= g;
    in_music_voice <= mus;
    start <= 1'b1;
    do @(negedge clk); while (xfer_count == n0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  // load any store word the next tick would read before it was written
  task automatic tick();
    logic [31:0] idx;
    logic [15:0] a;
    for (int i = 0; i < NV; i++) begin
      idx = v_phase[i] >> 16;
      a = 16'(v_base[i] + idx);
      if (v_on[i] && idx < v_len[i] && !store_written[a])
        send(pvm_pkg::ACT_LOAD, a, 16'($urandom));
    end
    send(pvm_pkg::ACT_TICK);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (frames_due.size() != 0) @(negedge clk);
    repeat (TICK_CYCLES + 10) @(negedge clk);
  endtask

  task automatic set_gain(logic [9:0] g);
    int n0;
    drain();
    n0 = cfg_count;
    cfg_master_gain <= g;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_count == n0);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_idle_frame();
    tick();
    tick();
  endtask

  task automatic test_directed();
    send(pvm_pkg::ACT_LOAD, 16'h0000, 16'sh7FFF);
    send(pvm_pkg::ACT_LOAD, 16'h0001, 16'sh8000);
    send(pvm_pkg::ACT_LOAD, 16'hFFFF, 16'sh0000);
    send(pvm_pkg::ACT_LOAD, 16'h0002, 16'shFFFF);
    send(pvm_pkg::ACT_PLAY, 16'h0000, 0, 17'd0, 16'd32000, 0, 0, 0, 11'sd256, 1);
    send(pvm_pkg::ACT_PLAY, 16'h0000, 0, 17'd4, 16'd32000, 17'd1, 17'd3, 1, 11'sd1023, 1);
    send(pvm_pkg::ACT_PLAY, 16'hFFFF, 0, 17'd65536, 16'd0, 17'd65536, 17'd65536, 0,
         -11'sd1024, 0);
    send(pvm_pkg::ACT_PLAY, 16'h0001, 0, 17'd2, 16'd65535, 17'd5, 17'd1, 1, 11'sd300, 0);
    tick();
    tick();
    tick();
    for (int i = 0; i < NV; i++)
      send(pvm_pkg::ACT_PLAY, 16'(i), 0, 17'd3, 16'd16000, 0, 17'd2, i[0], 11'sd200, 0);
    tick();
    send(pvm_pkg::ACT_STOP);
    tick();
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        tick();
      end else if (r < 66) begin
        send(pvm_pkg::ACT_PLAY, 16'($urandom),
             16'($urandom),
             ($urandom_range(0, 15) == 0) ? 17'($urandom_range(0, 65536)) :
                                            17'($urandom_range(0, 48)),
             16'($urandom),
             ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 40)),
             ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 48)),
             $urandom_range(0, 1), 11'($urandom), $urandom_range(0, 3) == 0);
      end else if (r < 97) begin
        send(pvm_pkg::ACT_LOAD, 16'($urandom), 16'($urandom));
      end else begin
        send(pvm_pkg::ACT_STOP);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_frame();
    test_directed();
    set_gain(10'd1023);
    test_random(250);
    set_gain(10'd0);
    test_random(150);
    set_gain(10'($urandom));
    test_random(250);
    set_gain(pvm_pkg::MASTER_RESET);
    test_random(150);
    quiet = 1;
    test_random(200);
    drain();
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
